>>> src/msbm_pkg.sv
package msbm_pkg;

    // Field widths of one input item
    localparam int MODE_W  = 2;
    localparam int STACK_W = 4;
    localparam int COUNT_W = 7;
    localparam int BYTE_W  = 8;

    // Field widths of one result item
    localparam int HEIGHT_OUT_W = 7;

    // Packed stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    // Operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_PUSH       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVE_ONE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MOVE_BLOCK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ       = 2'd3;

endpackage

>>> src/multi_stack_block_mover.sv
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata: mode, source_stack, dest_stack, move_count,
//                                   push_value
// m_axis    out  m_tvalid/m_tready  m_tdata: top_value, top_height, is_empty, fault
//
// One item at a time. A sequencer drives a simple dual-port byte store (one write and
// one registered read per cycle) and a one-write-per-cycle height file.
// Push, read, refused moves: height fetches, checks, top-byte read, result; a bad stack
// number skips the top-byte read. A move adds the byte transfer and both height writes;
// the store moves one byte per cycle, read of byte i overlapped with write of byte i-1.
// rst_n clears the heights and the sequencer at once; the byte store is not
// cleared. s_tready is high only when no item is in flight; a result waits in
// its output register until m_tready, and the next item is taken after that.
module multi_stack_block_mover #(
    parameter int STACK_COUNT = 16,
    parameter int STACK_DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [1:0] mode, [5:2] source_stack, [9:6] dest_stack, [16:10] move_count,
    // [24:17] push_value, [31:25] zero
    input  logic [msbm_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] top_value, [14:8] top_height, [15] is_empty, [16] fault, [23:17] zero
    output logic [msbm_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import msbm_pkg::*;

    localparam int SW  = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
    localparam int HW  = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_COUNT * STACK_DEPTH);
    localparam int MEM_DEPTH = STACK_COUNT * STACK_DEPTH;
    localparam int CW  = ((HW > COUNT_W) ? HW : COUNT_W) + 1;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HS   = 4'd1;   // fetch source height
    localparam logic [3:0] S_HD   = 4'd2;   // fetch destination height
    localparam logic [3:0] S_CHK  = 4'd3;   // range / fault checks, push write
    localparam logic [3:0] S_MOVE = 4'd4;   // byte transfer loop
    localparam logic [3:0] S_UPD  = 4'd5;   // write source height
    localparam logic [3:0] S_UPD2 = 4'd6;   // write destination height
    localparam logic [3:0] S_TOP  = 4'd7;   // read top byte
    localparam logic [3:0] S_OUT  = 4'd8;   // hold result

    // Control state
    logic [3:0]          state_reg, state_next;
    logic [HW-1:0]       heights_reg [STACK_COUNT];
    logic [COUNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic                wr_pend_reg, wr_pend_next;

    // Item and working registers
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [STACK_W-1:0]  src_reg, src_next;
    logic [STACK_W-1:0]  dst_reg, dst_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [BYTE_W-1:0]   val_reg, val_next;
    logic [HW-1:0]       hs_reg, hs_next;
    logic [HW-1:0]       hd_reg, hd_next;
    logic [AW-1:0]       src_base_reg, src_base_next;
    logic [AW-1:0]       dst_base_reg, dst_base_next;
    logic [AW-1:0]       rep_base_reg, rep_base_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic [AW-1:0]       wr_addr_reg, wr_addr_next;
    logic [HW-1:0]       rep_h_reg, rep_h_next;
    logic                fault_reg, fault_next;

    // Byte store
    logic [BYTE_W-1:0]   store_mem [MEM_DEPTH];
    logic [BYTE_W-1:0]   rdata_reg;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [BYTE_W-1:0]   mem_wdata;

    // Height file write port
    logic                ht_we;
    logic [SW-1:0]       ht_widx;
    logic [HW-1:0]       ht_wdata;

    // Decode helpers
    logic [SW-1:0]       src_idx, dst_idx;
    logic                src_ok, dst_ok, is_move, under, over, full;

    assign src_idx = SW'(src_reg);
    assign dst_idx = SW'(dst_reg);
    assign src_ok  = 32'(src_reg) < STACK_COUNT;
    assign dst_ok  = 32'(dst_reg) < STACK_COUNT;
    assign is_move = (mode_reg == MODE_MOVE_ONE) || (mode_reg == MODE_MOVE_BLOCK);
    assign under   = CW'(cnt_reg) > CW'(hs_reg);
    assign over    = (CW'(hd_reg) + CW'(cnt_reg)) > CW'(STACK_DEPTH);
    assign full    = 32'(hs_reg) >= STACK_DEPTH;

    always_comb
    begin
        state_next    = state_reg;
        rd_cnt_next   = rd_cnt_reg;
        wr_pend_next  = wr_pend_reg;
        mode_next     = mode_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        cnt_next      = cnt_reg;
        val_next      = val_reg;
        hs_next       = hs_reg;
        hd_next       = hd_reg;
        src_base_next = src_base_reg;
        dst_base_next = dst_base_reg;
        rep_base_next = rep_base_reg;
        rd_addr_next  = rd_addr_reg;
        wr_addr_next  = wr_addr_reg;
        rep_h_next    = rep_h_reg;
        fault_next    = fault_reg;

        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = rdata_reg;
        mem_re    = 1'b0;
        mem_raddr = rd_addr_reg;
        ht_we     = 1'b0;
        ht_widx   = src_idx;
        ht_wdata  = hs_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tdata[1:0];
                    src_next   = s_tdata[5:2];
                    dst_next   = s_tdata[9:6];
                    cnt_next   = s_tdata[16:10];
                    val_next   = s_tdata[24:17];
                    state_next = S_HS;
                end
            end
            S_HS:
            begin
                hs_next       = heights_reg[src_idx];
                src_base_next = AW'(src_idx) * AW'(STACK_DEPTH);
                state_next    = S_HD;
            end
            S_HD:
            begin
                hd_next       = heights_reg[dst_idx];
                dst_base_next = AW'(dst_idx) * AW'(STACK_DEPTH);
                state_next    = S_CHK;
            end
            S_CHK:
            begin
                fault_next = 1'b0;
                if (!src_ok || (is_move && !dst_ok))
                begin
                    // bad stack number: empty report, no store access
                    rep_h_next = '0;
                    fault_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (mode_reg == MODE_READ)
                begin
                    rep_base_next = src_base_reg;
                    rep_h_next    = hs_reg;
                    state_next    = S_TOP;
                end
                else if (mode_reg == MODE_PUSH)
                begin
                    rep_base_next = src_base_reg;
                    if (full)
                    begin
                        rep_h_next = hs_reg;
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = src_base_reg + AW'(hs_reg);
                        mem_wdata  = val_reg;
                        ht_we      = 1'b1;
                        ht_widx    = src_idx;
                        ht_wdata   = hs_reg + HW'(1);
                        rep_h_next = hs_reg + HW'(1);
                    end
                    state_next = S_TOP;
                end
                else
                begin
                    rep_base_next = dst_base_reg;
                    rep_h_next    = hd_reg;
                    if ((src_reg == dst_reg) || (cnt_reg == '0))
                    begin
                        state_next = S_TOP;
                    end
                    else if (under || over)
                    begin
                        fault_next = 1'b1;
                        state_next = S_TOP;
                    end
                    else
                    begin
                        // one-at-a-time walks down from the top, block walks up
                        if (mode_reg == MODE_MOVE_ONE)
                            rd_addr_next = src_base_reg + AW'(hs_reg) - AW'(1);
                        else
                            rd_addr_next = src_base_reg + AW'(hs_reg) - AW'(cnt_reg);
                        wr_addr_next = dst_base_reg + AW'(hd_reg);
                        rd_cnt_next  = cnt_reg;
                        wr_pend_next = 1'b0;
                        state_next   = S_MOVE;
                    end
                end
            end
            S_MOVE:
            begin
                if (rd_cnt_reg != '0)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = rd_addr_reg;
                    rd_cnt_next = rd_cnt_reg - COUNT_W'(1);
                    if (mode_reg == MODE_MOVE_ONE)
                        rd_addr_next = rd_addr_reg - AW'(1);
                    else
                        rd_addr_next = rd_addr_reg + AW'(1);
                end
                wr_pend_next = (rd_cnt_reg != '0);
                if (wr_pend_reg)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = wr_addr_reg;
                    mem_wdata    = rdata_reg;
                    wr_addr_next = wr_addr_reg + AW'(1);
                end
                if ((rd_cnt_reg == '0) && wr_pend_reg)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                ht_we      = 1'b1;
                ht_widx    = src_idx;
                ht_wdata   = hs_reg - HW'(cnt_reg);
                state_next = S_UPD2;
            end
            S_UPD2:
            begin
                ht_we      = 1'b1;
                ht_widx    = dst_idx;
                ht_wdata   = hd_reg + HW'(cnt_reg);
                rep_h_next = hd_reg + HW'(cnt_reg);
                state_next = S_TOP;
            end
            S_TOP:
            begin
                mem_re     = (rep_h_reg != '0);
                mem_raddr  = rep_base_reg + AW'(rep_h_reg) - AW'(1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_cnt_reg  <= '0;
            wr_pend_reg <= 1'b0;
            for (int i = 0; i < STACK_COUNT; i++)
                heights_reg[i] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            wr_pend_reg <= wr_pend_next;
            if (ht_we)
                heights_reg[ht_widx] <= ht_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        cnt_reg      <= cnt_next;
        val_reg      <= val_next;
        hs_reg       <= hs_next;
        hd_reg       <= hd_next;
        src_base_reg <= src_base_next;
        dst_base_reg <= dst_base_next;
        rep_base_reg <= rep_base_next;
        rd_addr_reg  <= rd_addr_next;
        wr_addr_reg  <= wr_addr_next;
        rep_h_reg    <= rep_h_next;
        fault_reg    <= fault_next;
    end

    // Byte store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= store_mem[mem_raddr];
    end

    // Result: empty stack reads as zero
    logic                empty;
    assign empty    = (rep_h_reg == '0);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {7'd0, fault_reg, empty, HEIGHT_OUT_W'(rep_h_reg),
                       empty ? BYTE_W'(0) : rdata_reg};

    // Checks
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
        else $error("item accepted while busy or result raised too early");

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("ready and result valid at once");

    a_height_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ht_we |-> (32'(ht_wdata) <= STACK_DEPTH))
        else $error("stack height written beyond depth");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("store read and write hit the same entry");

endmodule

>>> bench/tb_multi_stack_block_mover.sv
`timescale 1ns / 100ps

module tb_multi_stack_block_mover;

    import msbm_pkg::*;

    localparam int STACK_COUNT = 16;
    localparam int STACK_DEPTH = 64;
    localparam int CYCLE_LIMIT = 1000000;
    // Worst move is 64 bytes, plus a receiver stall.
    localparam int TAIL_CYCLES = 200;
    localparam int RANDOM_ITEMS = 1080;

    // Input item, first field in the low bits.
    typedef struct packed {
        logic [6:0]         pad;
        logic [BYTE_W-1:0]  push_value;
        logic [COUNT_W-1:0] move_count;
        logic [STACK_W-1:0] dest_stack;
        logic [STACK_W-1:0] source_stack;
        logic [MODE_W-1:0]  mode;
    } cmd_item_t;

    // Result item, first field in the low bits.
    typedef struct packed {
        logic [6:0]              pad;
        logic                    fault;
        logic                    is_empty;
        logic [HEIGHT_OUT_W-1:0] top_height;
        logic [BYTE_W-1:0]       top_value;
    } top_report_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    multi_stack_block_mover #(
        .STACK_COUNT (STACK_COUNT),
        .STACK_DEPTH (STACK_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Commands waiting to be sent, and reports predicted for accepted commands.
    cmd_item_t   cmd_q[$];
    top_report_t top_reports_q[$];

    // Predictor's copy of the stacks.
    logic [7:0] stack_bytes [STACK_COUNT][STACK_DEPTH];
    int         stack_level [STACK_COUNT];

    // Heights as the generator expects them; used only to steer stimulus.
    int gen_level [STACK_COUNT];
    int n_queued;

    int fail_count;
    int cycle_count;
    int send_gap, send_calm;
    int recv_stall, recv_calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one command to the stack copy, returns the report
    // of the addressed stack (source for push/read, dest for moves).
    // ------------------------------------------------------------------
    function automatic top_report_t stack_apply(cmd_item_t it);
        top_report_t r;
        int          owner;
        int          hs;
        int          hd;
        int          cnt;
        int          h;
        logic        ok;
        logic        flt;
        r     = '0;
        ok    = 1'b1;
        flt   = 1'b0;
        cnt   = it.move_count;
        if (it.mode == MODE_PUSH || it.mode == MODE_READ)
        begin
            owner = it.source_stack;
            if (owner >= STACK_COUNT)
            begin
                ok  = 1'b0;
                flt = 1'b1;
            end
            else if (it.mode == MODE_PUSH)
            begin
                if (stack_level[owner] >= STACK_DEPTH)
                    flt = 1'b1;     // full stack refuses the byte
                else
                begin
                    stack_bytes[owner][stack_level[owner]] = it.push_value;
                    stack_level[owner]++;
                end
            end
        end
        else
        begin
            owner = it.dest_stack;
            if (it.source_stack >= STACK_COUNT || it.dest_stack >= STACK_COUNT)
            begin
                ok  = 1'b0;
                flt = 1'b1;
            end
            else if (it.source_stack != it.dest_stack && cnt != 0)
            begin
                hs = stack_level[it.source_stack];
                hd = stack_level[it.dest_stack];
                if (cnt > hs || hd + cnt > STACK_DEPTH)
                    flt = 1'b1;     // underflow or overflow: no change
                else
                begin
                    // one-at-a-time reverses the bytes, block keeps their order
                    for (int i = 0; i < cnt; i++)
                        stack_bytes[it.dest_stack][hd + i] = (it.mode == MODE_MOVE_ONE) ?
                            stack_bytes[it.source_stack][hs - 1 - i] :
                            stack_bytes[it.source_stack][hs - cnt + i];
                    stack_level[it.source_stack] = hs - cnt;
                    stack_level[it.dest_stack]   = hd + cnt;
                end
            end
        end
        h            = ok ? stack_level[owner] : 0;
        r.top_value  = (h > 0) ? stack_bytes[owner][h - 1] : 8'd0;
        r.top_height = h[HEIGHT_OUT_W-1:0];
        r.is_empty   = (h == 0);
        r.fault      = flt;
        return r;
    endfunction

    // Gap length: mostly none or short, a few long, now and then a calm stretch.
    function automatic int next_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r == 0)
        begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 110)
            return 0;
        if (r < 190)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Queue one command and track the heights it leads to.
    function automatic void add_cmd(logic [MODE_W-1:0] md, int src, int dst, int cnt, int val);
        cmd_item_t it;
        it              = '0;
        it.mode         = md;
        it.source_stack = STACK_W'(src);
        it.dest_stack   = STACK_W'(dst);
        it.move_count   = COUNT_W'(cnt);
        it.push_value   = BYTE_W'(val);
        cmd_q.insert(cmd_q.size(), it);
        n_queued++;
        if (md == MODE_PUSH)
        begin
            if (gen_level[src] < STACK_DEPTH)
                gen_level[src]++;
        end
        else if (md != MODE_READ && src != dst && cnt != 0 && cnt <= gen_level[src]
                 && gen_level[dst] + cnt <= STACK_DEPTH)
        begin
            gen_level[src] -= cnt;
            gen_level[dst] += cnt;
        end
    endfunction

    function automatic logic [MODE_W-1:0] any_move();
        return $urandom_range(0, 1) ? MODE_MOVE_ONE : MODE_MOVE_BLOCK;
    endfunction

    // Legal move with random content; counts mostly small.
    function automatic void add_good_move();
        int src;
        int dst;
        int maxc;
        int cnt;
        src = $urandom_range(0, STACK_COUNT - 1);
        for (int t = 0; t < 8 && gen_level[src] == 0; t++)
            src = $urandom_range(0, STACK_COUNT - 1);
        dst = $urandom_range(0, STACK_COUNT - 1);
        for (int t = 0; t < 8 && (dst == src || gen_level[dst] == STACK_DEPTH); t++)
            dst = $urandom_range(0, STACK_COUNT - 1);
        maxc = STACK_DEPTH - gen_level[dst];
        if (gen_level[src] < maxc)
            maxc = gen_level[src];
        if (dst == src || maxc == 0)
        begin
            add_cmd(MODE_PUSH, src, $urandom, $urandom, $urandom);
            return;
        end
        if ($urandom_range(0, 3) != 0)
            cnt = $urandom_range(1, (maxc < 6) ? maxc : 6);
        else
            cnt = $urandom_range(1, maxc);
        add_cmd(any_move(), src, dst, cnt, $urandom);
    endfunction

    // Refused or no-op moves: zero count, same stack, underflow, overflow.
    function automatic void add_bad_move();
        int src;
        int dst;
        int lo;
        src = $urandom_range(0, STACK_COUNT - 1);
        dst = $urandom_range(0, STACK_COUNT - 1);
        case ($urandom_range(0, 3))
            0: add_cmd(any_move(), src, dst, 0, $urandom);
            1: add_cmd(any_move(), src, src, $urandom_range(0, 127), $urandom);
            2: add_cmd(any_move(), src, dst, $urandom_range(gen_level[src] + 1, 127), $urandom);
            default:
            begin
                lo = STACK_DEPTH + 1 - gen_level[dst];
                add_cmd(any_move(), src, dst, $urandom_range(lo, 127), $urandom);
            end
        endcase
    endfunction

    // Fill one stack to the top, push once more, move all of it into an
    // empty stack, then try to overflow that one.
    function automatic void add_fill_run();
        int s;
        int e;
        int x;
        s = $urandom_range(0, STACK_COUNT - 1);
        while (gen_level[s] < STACK_DEPTH)
            add_cmd(MODE_PUSH, s, $urandom, $urandom, $urandom);
        add_cmd(MODE_PUSH, s, $urandom, $urandom, $urandom);
        e = -1;
        for (int i = 0; i < STACK_COUNT; i++)
            if (e < 0 && gen_level[i] == 0)
                e = i;
        if (e < 0)
            return;
        add_cmd(any_move(), s, e, STACK_DEPTH, $urandom);
        x = (e + 1) % STACK_COUNT;
        if (gen_level[x] == 0)
            add_cmd(MODE_PUSH, x, $urandom, $urandom, $urandom);
        add_cmd(any_move(), x, e, 1, $urandom);
    endfunction

    function automatic void add_random_items(int upto);
        int r;
        int fills;
        fills = 0;
        while (n_queued < upto)
        begin
            r = $urandom_range(0, 99);
            if (r < 1 && fills < 3)
            begin
                add_fill_run();
                fills++;
            end
            else if (r < 29)
                add_cmd(MODE_PUSH, $urandom_range(0, STACK_COUNT - 1), $urandom, $urandom,
                        $urandom);
            else if (r < 75)
                add_good_move();
            else if (r < 86)
                add_cmd(MODE_READ, $urandom_range(0, STACK_COUNT - 1), $urandom, $urandom,
                        $urandom);
            else
                add_bad_move();
        end
    endfunction

    // Sender pause: wait for every queued command to go out and come back.
    // Sampled at the falling edge, once all clocked updates have settled.
    task automatic drain();
        @(negedge clk);
        while (cmd_q.size() != 0 || s_tvalid || top_reports_q.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence: directed corner cases, then two random halves with a full
    // drain in between.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        fail_count = 0;
        n_queued   = 0;
        for (int i = 0; i < STACK_COUNT; i++)
        begin
            gen_level[i]   = 0;
            stack_level[i] = 0;
        end

        add_cmd(MODE_READ,       7,  0,   0, 8'h00);    // empty stack
        add_cmd(MODE_PUSH,       0, 15, 127, 8'h00);
        add_cmd(MODE_PUSH,      15,  0,   0, 8'hFF);
        add_cmd(MODE_PUSH,       0,  0,   0, 8'hA5);
        add_cmd(MODE_PUSH,       0,  0,   0, 8'h5A);
        add_cmd(MODE_READ,       0, 15, 127, 8'hFF);
        add_cmd(MODE_MOVE_ONE,   0,  7,   2, 8'h00);    // reversed order
        add_cmd(MODE_READ,       7,  0,   0, 8'h00);
        add_cmd(MODE_MOVE_BLOCK, 7, 15,   2, 8'h00);    // order kept
        add_cmd(MODE_READ,      15,  0,   0, 8'h00);
        add_cmd(MODE_MOVE_ONE,   0,  7,   0, 8'h00);    // zero count
        add_cmd(MODE_MOVE_BLOCK, 15, 15,  5, 8'h00);    // same stack
        add_cmd(MODE_MOVE_ONE,  15, 15, 127, 8'hFF);
        add_cmd(MODE_MOVE_ONE,  15,  3, 127, 8'h00);    // underflow, count bit 6
        add_cmd(MODE_MOVE_BLOCK, 3,  4,   1, 8'h00);    // underflow from empty
        add_cmd(MODE_MOVE_BLOCK, 15, 0,   3, 8'h00);
        add_cmd(MODE_MOVE_ONE,   0, 15,   4, 8'h00);
        add_cmd(MODE_READ,       0,  0,   0, 8'h00);
        add_cmd(MODE_READ,      15, 15,   0, 8'hFF);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        drain();
        add_random_items(n_queued + RANDOM_ITEMS / 2);
        drain();
        add_random_items(n_queued + RANDOM_ITEMS / 2);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && top_reports_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Driver: one item held until accepted, random gaps between items.
    // The prediction is made as the item is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            send_gap  = 0;
            send_calm = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                top_reports_q.insert(top_reports_q.size(),
                                     stack_apply(cmd_item_t'(s_tdata)));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (cmd_q.size() != 0)
                begin
                    s_tdata  <= cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap = next_gap(send_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure, each report checked against the oldest
    // prediction.
    always @(posedge clk or negedge rst_n)
    begin
        top_report_t got;
        top_report_t want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_stall = 0;
            recv_calm  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = top_report_t'(m_tdata);
                if (top_reports_q.size() == 0)
                begin
                    $error("report with no command outstanding: %06h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = top_reports_q.pop_front();
                    if (got.top_value !== want.top_value)
                    begin
                        $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
                        fail_count++;
                    end
                    if (got.top_height !== want.top_height)
                    begin
                        $error("top_height: expected %0d, got %0d",
                               want.top_height, got.top_height);
                        fail_count++;
                    end
                    if (got.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                        fail_count++;
                    end
                    if (got.fault !== want.fault)
                    begin
                        $error("fault: expected %0d, got %0d", want.fault, got.fault);
                        fail_count++;
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_stall = next_gap(recv_calm);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
        cycle_count = 0;

endmodule
